### rtl/kmpsm_pkg.sv
// kmpsm_pkg: shared types and codes for the kmp stream matcher
// used by every file of the block but kmpsm_ram; no dependencies
`timescale 1ns / 1ps

package kmpsm_pkg;

    localparam int CH_W    = 8;
    localparam int START_W = 16;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // input item as it arrives on the port
    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] ch;
        logic            first;
    } t_in_item;

    // result item
    typedef struct packed {
        logic               match;
        logic [START_W-1:0] match_start;
        logic               pattern_overflow;
    } t_out_item;

    // classified operation handed from the front to the engine
    typedef enum logic [1:0] {
        OP_PAT_APPEND   = 2'd0,
        OP_PAT_RESTART  = 2'd1,
        OP_TEXT_STEP    = 2'd2,
        OP_TEXT_RESTART = 2'd3
    } t_op_code;

    typedef struct packed {
        t_op_code        code;
        logic [CH_W-1:0] ch;
    } t_op;

    // handshake bundle between two stages
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_stream;

endpackage

### rtl/kmp_stream_matcher_core.sv
// kmp_stream_matcher_core: top level of the streaming knuth-morris-pratt matcher
// depends on kmpsm_pkg, kmpsm_front, kmpsm_fifo, kmpsm_engine, kmpsm_ram
//
// usage: one valid/ready input channel carries items {cmd, ch, first}; cmd 0
// appends a pattern byte (first restarts the pattern), cmd 1 steps a text
// byte (first restarts the text at position zero). every item yields exactly
// one result item {match, match_start, pattern_overflow} on the output
// channel, in order. the failure table grows by one entry per stored pattern
// byte. an item passes the front register and the queue to the engine. an item
// that needs no compare (a text byte with no pattern, a dropped pattern byte,
// or one whose failure index is minus one) loads the result register from the
// idle state; the rest go to the walk state, which compares one stored pattern
// byte per cycle, while the result register is free, through the registered
// read port of the pattern memory and follows one failure link per mismatch.
// the engine takes no new operation until it is back in the idle state.
// the front register and a two-entry queue keep accepting items while a
// result waits; a stalled receiver holds the engine, then the queue fills and
// ready drops. reset clears all counters at once; the pattern and failure
// memories hold no reset value and need no clearing pass.
`timescale 1ns / 1ps

module kmp_stream_matcher_core #(
    parameter int MAX_PATTERN    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  kmpsm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kmpsm_pkg::t_out_item o_out_item
);

    // front stage to queue
    kmpsm_pkg::t_op_stream w_push;
    logic                  w_push_ready;
    // queue head to engine
    kmpsm_pkg::t_op_stream w_head;
    logic                  w_pop;

    // accept and classify
    kmpsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // decouples the front from the engine
    kmpsm_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // pattern build, failure-chain walk and result register
    kmpsm_engine #(
        .MAX_PATTERN    (MAX_PATTERN),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // an item accepted into an empty front register shows up there next cycle
    a_front_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_push.valid) |=> w_push.valid)
        else $error("accepted item missing from front register");

    // the engine only takes an operation the queue actually holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("engine popped an empty queue");

    // a text match and a dropped pattern byte never share one result
    a_match_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.match && o_out_item.pattern_overflow))
        else $error("match and overflow flagged together");

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

### rtl/kmpsm_ram.sv
// kmpsm_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module kmpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kmpsm_front.sv
// kmpsm_front: input register that accepts items and classifies them into operations
// depends on kmpsm_pkg
`timescale 1ns / 1ps

module kmpsm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kmpsm_pkg::t_in_item   i_in_item,
    output kmpsm_pkg::t_op_stream o_push,
    input  logic                  i_push_ready
);

    logic            r_valid;
    kmpsm_pkg::t_op  r_op;
    kmpsm_pkg::t_op  w_op;
    logic            w_take;

    assign o_in_ready = !r_valid || i_push_ready;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        w_op.ch = i_in_item.ch;
        case ({i_in_item.cmd, i_in_item.first})
            {kmpsm_pkg::CMD_PATTERN, 1'b0}: w_op.code = kmpsm_pkg::OP_PAT_APPEND;
            {kmpsm_pkg::CMD_PATTERN, 1'b1}: w_op.code = kmpsm_pkg::OP_PAT_RESTART;
            {kmpsm_pkg::CMD_TEXT, 1'b0}:    w_op.code = kmpsm_pkg::OP_TEXT_STEP;
            {kmpsm_pkg::CMD_TEXT, 1'b1}:    w_op.code = kmpsm_pkg::OP_TEXT_RESTART;
            default:                        w_op.code = kmpsm_pkg::OP_TEXT_STEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= w_op;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.op    = r_op;

endmodule

### rtl/kmpsm_fifo.sv
// kmpsm_fifo: two-entry operation queue between the front and the engine
// depends on kmpsm_pkg
`timescale 1ns / 1ps

module kmpsm_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmpsm_pkg::t_op_stream i_push,
    output logic                  o_push_ready,
    output kmpsm_pkg::t_op_stream o_head,
    input  logic                  i_pop
);

    kmpsm_pkg::t_op r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_mem[r_rd_ptr];

endmodule

### rtl/kmpsm_engine.sv
// kmpsm_engine: executes pattern and text operations, walks the failure chain, holds results
// depends on kmpsm_pkg and kmpsm_ram
`timescale 1ns / 1ps

module kmpsm_engine #(
    parameter int MAX_PATTERN    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmpsm_pkg::t_op_stream i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kmpsm_pkg::t_out_item  o_out_item
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW = POSITION_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_eng_state;

    t_eng_state r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_build, n_build;     // failure index of next pattern byte, plus one
    logic [LW-1:0] r_match, n_match;
    logic [LW-1:0] r_cur, n_cur;         // chain position being compared, plus one
    logic [PW-1:0] r_pos, n_pos;
    logic [kmpsm_pkg::CH_W-1:0] r_ch, n_ch;
    logic r_is_text, n_is_text;

    logic                       r_out_valid;
    kmpsm_pkg::t_out_item       r_out_item;
    kmpsm_pkg::t_out_item       w_out_item;
    logic                       w_out_load;
    logic                       w_out_free;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [LW-1:0]              w_rd_src;
    logic [LW-1:0]              w_rd_m1;
    logic [kmpsm_pkg::CH_W-1:0] w_rd_ch;
    logic [LW-1:0]              w_rd_fail;

    logic [LW-1:0] w_len_eff;
    logic [LW-1:0] w_build_eff;
    logic [LW-1:0] w_k;
    logic          w_finish;
    logic          w_restart;
    logic [PW-1:0] w_start;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rd_m1    = w_rd_src - LW'(1);

    kmpsm_ram #(
        .WIDTH (kmpsm_pkg::CH_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_head.op.ch),
        .i_raddr (w_rd_m1[AW-1:0]),
        .o_rdata (w_rd_ch)
    );

    kmpsm_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PATTERN)
    ) u_failure_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_build_eff),
        .i_raddr (w_rd_m1[AW-1:0]),
        .o_rdata (w_rd_fail)
    );

    assign w_restart   = (i_head.op.code == kmpsm_pkg::OP_PAT_RESTART);
    assign w_len_eff   = w_restart ? '0 : r_len;
    assign w_build_eff = w_restart ? '0 : r_build;
    assign w_waddr     = w_len_eff[AW-1:0];
    assign w_start     = r_pos + PW'(1) - PW'(r_len);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_build    = r_build;
        n_match    = r_match;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_ch       = r_ch;
        n_is_text  = r_is_text;
        o_pop      = 1'b0;
        w_we       = 1'b0;
        w_rd_src   = r_cur;
        w_out_load = 1'b0;
        w_out_item = '0;
        w_finish   = 1'b0;
        w_k        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid && w_out_free) begin
                    o_pop = 1'b1;
                    n_ch  = i_head.op.ch;
                    case (i_head.op.code)
                        kmpsm_pkg::OP_PAT_APPEND, kmpsm_pkg::OP_PAT_RESTART: begin
                            n_is_text = 1'b0;
                            if (w_restart) begin
                                n_len   = '0;
                                n_build = '0;
                                n_match = '0;
                            end
                            if (w_len_eff == LW'(MAX_PATTERN)) begin
                                // store full: byte dropped
                                w_out_load                  = 1'b1;
                                w_out_item.pattern_overflow = 1'b1;
                            end else begin
                                w_we  = 1'b1;
                                n_len = w_len_eff + LW'(1);
                                if (w_build_eff == '0) begin
                                    n_build    = LW'(1);
                                    w_out_load = 1'b1;
                                end else begin
                                    n_cur    = w_build_eff;
                                    w_rd_src = w_build_eff;
                                    n_state  = ST_WALK;
                                end
                            end
                        end
                        kmpsm_pkg::OP_TEXT_STEP, kmpsm_pkg::OP_TEXT_RESTART: begin
                            n_is_text = 1'b1;
                            if (i_head.op.code == kmpsm_pkg::OP_TEXT_RESTART) begin
                                n_pos   = '0;
                                n_match = '0;
                            end
                            if (r_len == '0) begin
                                // no pattern: only the position moves
                                n_pos      = n_pos + PW'(1);
                                w_out_load = 1'b1;
                            end else begin
                                n_cur    = n_match + LW'(1);
                                w_rd_src = n_match + LW'(1);
                                n_state  = ST_WALK;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (w_out_free) begin
                    if (w_rd_ch == r_ch) begin
                        w_finish = 1'b1;
                        w_k      = r_cur;
                    end else if (w_rd_fail == '0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_cur    = w_rd_fail;
                        w_rd_src = w_rd_fail;
                    end
                end
                if (w_finish) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_is_text) begin
                        n_pos = r_pos + PW'(1);
                        if (w_k == r_len) begin
                            w_out_item.match       = 1'b1;
                            w_out_item.match_start = kmpsm_pkg::START_W'(w_start);
                            n_match                = '0;
                        end else begin
                            n_match = w_k;
                        end
                    end else begin
                        n_build = w_k + LW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_build     <= '0;
            r_match     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_build <= n_build;
            r_match <= n_match;
            r_pos   <= n_pos;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_ch      <= n_ch;
        r_is_text <= n_is_text;
        if (w_out_load) begin
            r_out_item <= w_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
